### rtl/tdwfp_pkg.sv
// Shared types and constants for the tail-delimited word frame parser.
// No dependencies.
package tdwfp_pkg;

	localparam int PACKET_BYTES = 256;
	localparam int WORD_BYTES   = 4;
	localparam int TAIL_LEN     = 4;
	localparam int IDX_W        = 6;
	localparam int QUEUE_DEPTH  = 2;

	localparam int                CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_PATTERN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WORD_COUNT = 1'b1;

	localparam logic [31:0]      TAIL_RESET = 32'h7F80_0000;
	localparam logic [IDX_W-1:0] MWC_RESET  = 6'd63;

	// frame handed from front to back: buffer bank and payload word count
	typedef struct packed {
		logic             bank;
		logic [IDX_W-1:0] words;
	} desc_t;

	// back tells front a bank has been read out
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

endpackage

### rtl/tdwfp_ram.sv
// Generic simple dual-port RAM, registered read.
// No dependencies.
module tdwfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/tdwfp_front.sv
// Front end: accepts bytes, tracks tail window, writes words into the frame buffer
// and classifies each frame at its tail. Depends on tdwfp_pkg.
module tdwfp_front #(
	parameter int PACKET_BYTES = tdwfp_pkg::PACKET_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       data_byte,
	input  logic [31:0]                      tail_pattern,
	input  logic [tdwfp_pkg::IDX_W-1:0]      max_word_count,
	input  tdwfp_pkg::release_t              rel,
	output logic                             push,
	output tdwfp_pkg::desc_t                 push_desc,
	output logic                             ram_we,
	output logic [$clog2(2*(PACKET_BYTES/tdwfp_pkg::WORD_BYTES))-1:0] ram_waddr,
	output logic [31:0]                      ram_wdata
);

	localparam int WORDS   = PACKET_BYTES / tdwfp_pkg::WORD_BYTES;
	localparam int WORD_AW = $clog2(WORDS);
	localparam int CW      = $clog2(PACKET_BYTES + 1);
	localparam int CMPW    = 8;

	logic [CW-1:0] count_q;
	logic [31:0]   window_q;
	logic          oversize_q;
	logic          bank_q;
	logic [1:0]    busy_q;

	logic          accept;
	logic          store;
	logic          ovf_nx;
	logic [CW-1:0] cnt_nx;
	logic [31:0]   win_nx;
	logic          match;
	logic          good;
	logic [CW-3:0] wcnt;
	logic [CW-3:0] pw;

	assign in_stall = busy_q[bank_q];
	assign accept   = in_valid && !in_stall;

	assign win_nx = {data_byte, window_q[31:8]};
	assign store  = !oversize_q && (count_q < CW'(PACKET_BYTES));
	assign ovf_nx = !store;
	assign cnt_nx = store ? count_q + CW'(1) : count_q;
	assign match  = (ovf_nx || cnt_nx >= CW'(tdwfp_pkg::TAIL_LEN)) && (win_nx == tail_pattern);
	assign wcnt   = cnt_nx[CW-1:2];
	assign pw     = wcnt - (CW-2)'(1);
	assign good   = match && !ovf_nx && (cnt_nx[1:0] == 2'd0) && (wcnt > (CW-2)'(1))
		&& (CMPW'(pw) <= CMPW'(max_word_count));

	assign ram_we    = accept && store && (cnt_nx[1:0] == 2'd0);
	assign ram_waddr = {bank_q, WORD_AW'(wcnt - (CW-2)'(1))};
	assign ram_wdata = win_nx;

	assign push            = accept && good;
	assign push_desc.bank  = bank_q;
	assign push_desc.words = tdwfp_pkg::IDX_W'(pw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			window_q   <= '0;
			oversize_q <= 1'b0;
			bank_q     <= 1'b0;
			busy_q     <= '0;
		end else begin
			if (accept) begin
				count_q    <= match ? '0 : cnt_nx;
				window_q   <= match ? '0 : win_nx;
				oversize_q <= match ? 1'b0 : ovf_nx;
				if (good) begin
					bank_q <= !bank_q;
				end
			end
			for (int b = 0; b < 2; b++) begin
				if (push && (bank_q == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (rel.valid && (rel.bank == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

### rtl/tdwfp_queue.sv
// Two-entry descriptor queue between front and back.
// Depends on tdwfp_pkg.
module tdwfp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tdwfp_pkg::desc_t push_desc,
	input  logic             pop,
	output logic             head_valid,
	output tdwfp_pkg::desc_t head_desc
);

	localparam int PW = $clog2(tdwfp_pkg::QUEUE_DEPTH);

	tdwfp_pkg::desc_t entry_q [tdwfp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      cnt_q;

	assign head_valid = (cnt_q != '0);
	assign head_desc  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

endmodule

### rtl/tdwfp_back.sv
// Back end: reads the words of a queued frame from the buffer and delivers them
// through an output register with a skid stage. Depends on tdwfp_pkg.
module tdwfp_back #(
	parameter int PACKET_BYTES = tdwfp_pkg::PACKET_BYTES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  tdwfp_pkg::desc_t            head_desc,
	output logic                        pop,
	output tdwfp_pkg::release_t         rel,
	output logic                        ram_re,
	output logic [$clog2(2*(PACKET_BYTES/tdwfp_pkg::WORD_BYTES))-1:0] ram_raddr,
	input  logic [31:0]                 ram_rdata,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [31:0]                 payload_word,
	output logic [tdwfp_pkg::IDX_W-1:0] word_index,
	output logic                        last_word
);

	localparam int WORD_AW = $clog2(PACKET_BYTES / tdwfp_pkg::WORD_BYTES);
	localparam int IW      = tdwfp_pkg::IDX_W;

	logic          active_q;
	logic          bank_q;
	logic [IW-1:0] words_q;
	logic [IW-1:0] k_q;

	logic          valid_s1;
	logic [IW-1:0] index_s1;
	logic          last_s1;

	logic          out_v_q;
	logic [31:0]   out_word_q;
	logic [IW-1:0] out_idx_q;
	logic          out_last_q;
	logic          skid_v_q;
	logic [31:0]   skid_word_q;
	logic [IW-1:0] skid_idx_q;
	logic          skid_last_q;

	logic          deliver;
	logic          issue;
	logic          is_last;
	logic [1:0]    occ;

	assign deliver = out_v_q && !out_stall;
	assign occ     = 2'(out_v_q) + 2'(skid_v_q) + 2'(valid_s1) - 2'(deliver);
	assign issue   = active_q && (occ < 2'd2);
	assign is_last = (k_q == words_q - IW'(1));
	assign pop     = !active_q && head_valid;

	assign rel.valid = issue && is_last;
	assign rel.bank  = bank_q;

	assign ram_re    = issue;
	assign ram_raddr = {bank_q, WORD_AW'(k_q)};

	assign out_valid    = out_v_q;
	assign payload_word = out_word_q;
	assign word_index   = out_idx_q;
	assign last_word    = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
			end else if (issue && is_last) begin
				active_q <= 1'b0;
			end
			valid_s1 <= issue;
			if (!out_v_q || deliver) begin
				out_v_q  <= skid_v_q || valid_s1;
				skid_v_q <= skid_v_q && valid_s1;
			end else if (valid_s1) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bank_q  <= head_desc.bank;
			words_q <= head_desc.words;
			k_q     <= '0;
		end else if (issue) begin
			k_q <= k_q + IW'(1);
		end
		if (issue) begin
			index_s1 <= k_q;
			last_s1  <= is_last;
		end
		if (!out_v_q || deliver) begin
			if (skid_v_q) begin
				out_word_q <= skid_word_q;
				out_idx_q  <= skid_idx_q;
				out_last_q <= skid_last_q;
				skid_word_q <= ram_rdata;
				skid_idx_q  <= index_s1;
				skid_last_q <= last_s1;
			end else begin
				out_word_q <= ram_rdata;
				out_idx_q  <= index_s1;
				out_last_q <= last_s1;
			end
		end else if (valid_s1) begin
			skid_word_q <= ram_rdata;
			skid_idx_q  <= index_s1;
			skid_last_q <= last_s1;
		end
	end

endmodule

### rtl/tail_delimited_word_frame_parser.sv
// Top level of the tail-delimited word frame parser: config registers, front end, descriptor
// queue, frame buffer and back end. Depends on tdwfp_pkg and the four tdwfp_* modules.
//
//  port group | dir | request contents
//  -----------+-----+------------------------------------------------
//  in         | in  | data_byte                   (valid / stall)
//  out        | out | payload_word, word_index, last_word (valid / stall)
//  cfg        | in  | cfg_index, cfg_data          (write enable only)
//
// One byte is taken per cycle; the front stalls only while both buffer banks
// hold frames waiting to be read out. The back delivers one word per cycle while
// the output is not stalled, pausing between frames; buffer reads are registered.
// Reset: async, active low; frame state, queue and output valid clear at once.
// Stall on the output fills a skid register, then throttles buffer reads.
module tail_delimited_word_frame_parser #(
	parameter int PACKET_BYTES = tdwfp_pkg::PACKET_BYTES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          data_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [31:0]                         payload_word,
	output logic [tdwfp_pkg::IDX_W-1:0]         word_index,
	output logic                                last_word,
	input  logic                                cfg_we,
	input  logic [tdwfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                         cfg_data
);

	localparam int RAM_DEPTH = 2 * (PACKET_BYTES / tdwfp_pkg::WORD_BYTES);
	localparam int RAM_AW    = $clog2(RAM_DEPTH);

	logic [31:0]                 tail_pattern_q;
	logic [tdwfp_pkg::IDX_W-1:0] max_word_count_q;

	tdwfp_pkg::release_t rel;
	tdwfp_pkg::desc_t    push_desc;
	tdwfp_pkg::desc_t    head_desc;
	logic                push;
	logic                pop;
	logic                head_valid;
	logic                ram_we;
	logic [RAM_AW-1:0]   ram_waddr;
	logic [31:0]         ram_wdata;
	logic                ram_re;
	logic [RAM_AW-1:0]   ram_raddr;
	logic [31:0]         ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_pattern_q   <= tdwfp_pkg::TAIL_RESET;
			max_word_count_q <= tdwfp_pkg::MWC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdwfp_pkg::REG_TAIL_PATTERN: begin
					tail_pattern_q <= cfg_data;
				end
				tdwfp_pkg::REG_MAX_WORD_COUNT: begin
					max_word_count_q <= cfg_data[tdwfp_pkg::IDX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tdwfp_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.tail_pattern   (tail_pattern_q),
		.max_word_count (max_word_count_q),
		.rel            (rel),
		.push           (push),
		.push_desc      (push_desc),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata)
	);

	tdwfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	tdwfp_ram #(.WIDTH(32), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tdwfp_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.pop          (pop),
		.rel          (rel),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_word (payload_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

endmodule

### rtl/tdwfp_checker.sv
// Port-level checks for the frame parser output, bound to the top level.
// Depends on tdwfp_pkg.
module tdwfp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [31:0]                 payload_word,
	input logic [tdwfp_pkg::IDX_W-1:0] word_index,
	input logic                        last_word
);

	logic [tdwfp_pkg::IDX_W-1:0] exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && !out_stall) begin
			exp_idx_q <= last_word ? '0 : word_index + tdwfp_pkg::IDX_W'(1);
		end
	end

	// words of a frame come in order, each frame starting at zero
	a_index_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_index == exp_idx_q)
		else $error("word_index out of sequence");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(payload_word)
			&& $stable(word_index) && $stable(last_word))
		else $error("stalled output changed");

	// a frame holds at most 63 words
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_index != 6'd63)
		else $error("word_index beyond frame limit");

endmodule

bind tail_delimited_word_frame_parser tdwfp_checker u_chk (.*);

### bench/tail_delimited_word_frame_parser_tb.sv
// Self-checking bench for tail_delimited_word_frame_parser: byte stream in, payload words out.
// Depends on tdwfp_pkg and the parser RTL; a scoreboard class predicts the words of each frame.
module tail_delimited_word_frame_parser_tb;
	import tdwfp_pkg::*;

	class word_frame_scoreboard;
		typedef struct packed {
			logic [31:0]      data;
			logic [IDX_W-1:0] idx;
			logic             last;
		} frame_word_t;

		logic [31:0]      tail_pattern = TAIL_RESET;
		logic [IDX_W-1:0] max_words    = MWC_RESET;
		logic [7:0]       frame_store [PACKET_BYTES];
		int unsigned      held         = 0;
		logic [31:0]      window       = '0;
		bit               oversize     = 1'b0;
		frame_word_t      pending_words [$];
		int               errors       = 0;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				REG_TAIL_PATTERN:   tail_pattern = value;
				REG_MAX_WORD_COUNT: max_words = value[IDX_W-1:0];
				default: ;
			endcase
		endfunction

		// one accepted request byte; queues the words of a frame that ends here
		function void take_byte(logic [7:0] b);
			int unsigned payload;
			int unsigned words;
			frame_word_t fw;
			window = {b, window[31:8]};
			if (!oversize) begin
				if (held < PACKET_BYTES) begin
					frame_store[held] = b;
					held++;
				end else begin
					oversize = 1'b1;
				end
			end
			if (!(oversize || held >= TAIL_LEN) || window != tail_pattern)
				return;
			payload = held - TAIL_LEN;
			words = payload / WORD_BYTES;
			if (!oversize && payload != 0 && payload % WORD_BYTES == 0 && words <= max_words) begin
				for (int k = 0; k < words; k++) begin
					fw.data = {frame_store[4*k+3], frame_store[4*k+2],
						frame_store[4*k+1], frame_store[4*k]};
					fw.idx  = k[IDX_W-1:0];
					fw.last = (k + 1 == words);
					pending_words.push_back(fw);
				end
			end
			held = 0;
			window = '0;
			oversize = 1'b0;
		endfunction

		function void check_word(logic [31:0] data, logic [IDX_W-1:0] idx, logic last);
			frame_word_t fw;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word %h idx %0d last %0b", $time, data, idx, last);
				errors++;
				return;
			end
			fw = pending_words.pop_front();
			if (fw.data !== data || fw.idx !== idx || fw.last !== last) begin
				$display("%0t: word mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
					$time, fw.data, fw.idx, fw.last, data, idx, last);
				errors++;
			end
		endfunction

		function bit frame_open();
			return held != 0 || oversize;
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           data_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [31:0]          payload_word;
	logic [IDX_W-1:0]     word_index;
	logic                 last_word;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	word_frame_scoreboard sb = new();
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned bytes_sent = 0;
	bit out_hold = 1'b0;

	tail_delimited_word_frame_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.payload_word(payload_word), .word_index(word_index), .last_word(last_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(payload_word, word_index, last_word);
		out_stall <= out_hold || ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_tail();
		for (int i = 0; i < 4; i++)
			send_byte(sb.tail_pattern[8*i +: 8]);
	endtask

	task automatic send_frame(input int unsigned payload_len);
		repeat (payload_len)
			send_byte(8'($urandom_range(255)));
		send_tail();
	endtask

	// close whatever frame is open so the parser holds nothing
	task automatic flush_frame();
		while (sb.frame_open())
			send_tail();
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] tail, input logic [IDX_W-1:0] mwc);
		cfg_we <= 1'b1;
		cfg_index <= REG_TAIL_PATTERN;
		cfg_data <= tail;
		@(posedge clk);
		cfg_index <= REG_MAX_WORD_COUNT;
		cfg_data <= 32'(mwc);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(REG_TAIL_PATTERN, tail);
		sb.write_reg(REG_MAX_WORD_COUNT, 32'(mwc));
	endtask

	task automatic random_frames(input int unsigned budget);
		int unsigned start;
		int unsigned pick;
		int unsigned mw;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			pick = $urandom_range(99);
			mw = sb.max_words;
			if (pick < 65)
				send_frame(4 * $urandom_range(mw < 8 ? mw : 8, 1));
			else if (pick < 73)
				send_frame(0);
			else if (pick < 83)
				send_frame(4 * $urandom_range(4, 0) + $urandom_range(3, 1));
			else if (pick < 90)
				send_frame(mw < 63 ? 4 * $urandom_range(mw + 3 > 63 ? 63 : mw + 3, mw + 1)
					: 4 * $urandom_range(3, 1) + 2);
			else
				repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
		end
		flush_frame();
		settle();
	endtask

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [7:0] seq [];
		seq = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h80, 8'h7F,
			8'h00, 8'h00, 8'h80, 8'h7F,
			8'h01, 8'h00, 8'h00, 8'h80, 8'h7F,
			8'h00, 8'h80, 8'h7F, 8'hAA, 8'h00, 8'h00, 8'h80, 8'h7F};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		data_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_TAIL_PATTERN;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default tail: two-word frame, empty payload, ragged payload, tail seen too early
		foreach (seq[i])
			send_byte(seq[i]);
		flush_frame();
		settle();

		configure($urandom, 6'd63);
		random_frames(40);

		configure(32'hFFFF_FFFF, 6'd1);
		send_idle_pct = 87;
		random_frames(40);

		configure(32'h0000_0000, 6'($urandom_range(20, 8)));
		send_idle_pct = 0;
		recv_stall_pct = 87;
		random_frames(40);

		configure($urandom, 6'd63);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		random_frames(40);

		// receiver holds off while frames keep coming, so both banks fill
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				out_hold = 1'b1;
				repeat (300) @(posedge clk);
				out_hold = 1'b0;
			end
		join_none
		repeat (3) send_frame(12);
		flush_frame();
		settle();

		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### tail_delimited_word_frame_parser.f
rtl/tdwfp_pkg.sv
rtl/tdwfp_ram.sv
rtl/tdwfp_front.sv
rtl/tdwfp_queue.sv
rtl/tdwfp_back.sv
rtl/tail_delimited_word_frame_parser.sv
rtl/tdwfp_checker.sv
bench/tail_delimited_word_frame_parser_tb.sv
